// ===== design/jac_pkg.sv =====
// Shared constants, types and a helper function for the joystick axis conditioner.
package jac_pkg;

  localparam int NUM_AXES    = 4;
  localparam int RAW_W       = 12;
  localparam int AXIS_W      = 10;
  localparam int KEY_W       = 4;
  localparam int TRIM_STEP_W = 7;
  localparam int TRIM_W      = 8;
  localparam int ZERO_W      = 11;
  localparam int SUM_W       = 15;
  localparam int OUT_W       = 13;

  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 48;

  localparam int CALIB_SAMPLES = 10;
  localparam int CALIB_W       = 4;

  localparam int FULL_SCALE      = 1000;
  localparam int RAW_MAX         = 4095;
  localparam int STICK_CENTER    = 500;
  localparam int TRIM_STEP_RESET = 10;

  localparam int AX_THROTTLE = 0;
  localparam int AX_YAW      = 1;
  localparam int AX_PITCH    = 2;
  localparam int AX_ROLL     = 3;

  // x*1000/4095 is taken as (x*SCALE_MUL) >> SCALE_SH, exact for every 12-bit x.
  localparam int     SCALE_SH    = 24;
  localparam longint SCALE_MUL_L =
    ((longint'(FULL_SCALE) << SCALE_SH) + longint'(RAW_MAX) - 1) / longint'(RAW_MAX);
  localparam int     SCALE_MUL_W = $clog2(SCALE_MUL_L + 1);
  localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = SCALE_MUL_W'(SCALE_MUL_L);
  localparam int     PROD_W      = RAW_W + SCALE_MUL_W;
  localparam int     QUO_W       = PROD_W - SCALE_SH;

  // Magnitude of a calibration sum divided by the sample count, exact below 2^SUM_W.
  localparam int     DIV_SH    = SUM_W + 5;
  localparam longint DIV_MUL_L =
    ((longint'(1) << DIV_SH) + longint'(CALIB_SAMPLES) - 1) / longint'(CALIB_SAMPLES);
  localparam int     DIV_MUL_W = $clog2(DIV_MUL_L + 1);
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'(DIV_MUL_L);
  localparam int     DPROD_W   = SUM_W + DIV_MUL_W;

  typedef enum logic [KEY_W-1:0] {
    KEY_NONE    = 4'd0,
    KEY_UP      = 4'd1,
    KEY_DN      = 4'd2,
    KEY_LT      = 4'd3,
    KEY_RT      = 4'd4,
    KEY_LX      = 4'd5,
    KEY_LX_LONG = 4'd6,
    KEY_RX      = 4'd7,
    KEY_RX_LONG = 4'd8
  } key_code_e;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
  } item_t;

  function automatic logic [AXIS_W-1:0] clamp_axis(input logic signed [OUT_W-1:0] v);
    logic [AXIS_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > OUT_W'(FULL_SCALE)) begin
      res = AXIS_W'(FULL_SCALE);
    end else begin
      res = v[AXIS_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== design/jac_lane.sv =====
// One axis lane: scales a raw reading to 1000 - x*1000/4095 over two registered stages.
module jac_lane (
  input  logic                          clk_i,
  input  logic                          en1_i,
  input  logic                          en2_i,
  input  logic [jac_pkg::RAW_W-1:0]     raw_i,
  output logic [jac_pkg::AXIS_W-1:0]    scaled_o
);

  logic [jac_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [jac_pkg::AXIS_W-1:0] scaled_q, scaled_d;
  logic [jac_pkg::QUO_W-1:0]  quo;

  assign prod_d = jac_pkg::PROD_W'(raw_i) * jac_pkg::PROD_W'(jac_pkg::SCALE_MUL);
  assign quo    = prod_q[jac_pkg::PROD_W-1:jac_pkg::SCALE_SH];
  assign scaled_d = jac_pkg::AXIS_W'(jac_pkg::QUO_W'(jac_pkg::FULL_SCALE) - quo);

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      prod_q <= prod_d;
    end
    if (en2_i) begin
      scaled_q <= scaled_d;
    end
  end

  assign scaled_o = scaled_q;

endmodule

// ===== design/jac_zdiv.sv =====
// Signed calibration sum divided by the sample count, truncating towards zero.
module jac_zdiv (
  input  logic signed [jac_pkg::SUM_W-1:0]  sum_i,
  output logic signed [jac_pkg::ZERO_W-1:0] quo_o
);

  logic                              neg;
  logic [jac_pkg::SUM_W-1:0]         mag;
  logic [jac_pkg::DPROD_W-1:0]       prod;
  logic [jac_pkg::ZERO_W-1:0]        qmag;

  always_comb begin
    neg  = sum_i[jac_pkg::SUM_W-1];
    mag  = neg ? jac_pkg::SUM_W'(-sum_i) : jac_pkg::SUM_W'(sum_i);
    prod = jac_pkg::DPROD_W'(mag) * jac_pkg::DPROD_W'(jac_pkg::DIV_MUL);
    qmag = prod[jac_pkg::DIV_SH +: jac_pkg::ZERO_W];
    quo_o = neg ? $signed(-qmag) : $signed(qmag);
  end

endmodule

// ===== design/jac_merge.sv =====
// Merging stage: trims, request flags, calibration sums, zero offsets and the result register.
module jac_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_wr_en_i,
  input  logic [jac_pkg::TRIM_STEP_W-1:0]     cfg_wr_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  jac_pkg::item_t                      item_i,
  input  logic [jac_pkg::AXIS_W-1:0]          scaled_i [jac_pkg::NUM_AXES],
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [jac_pkg::AXIS_W-1:0]          axis_o [jac_pkg::NUM_AXES],
  output logic                                stop_req_o,
  output logic                                hold_height_o
);

  logic [jac_pkg::TRIM_STEP_W-1:0]     trim_step_q;
  logic signed [jac_pkg::TRIM_W-1:0]   pitch_trim_q, pitch_trim_d;
  logic signed [jac_pkg::TRIM_W-1:0]   roll_trim_q, roll_trim_d;
  logic signed [jac_pkg::TRIM_W-1:0]   step;
  logic signed [jac_pkg::ZERO_W-1:0]   zero_q [jac_pkg::NUM_AXES];
  logic signed [jac_pkg::ZERO_W-1:0]   zero_div [jac_pkg::NUM_AXES];
  logic signed [jac_pkg::SUM_W-1:0]    sum_q [jac_pkg::NUM_AXES];
  logic signed [jac_pkg::SUM_W-1:0]    sum_d [jac_pkg::NUM_AXES];
  logic signed [jac_pkg::SUM_W-1:0]    meas [jac_pkg::NUM_AXES];
  logic signed [jac_pkg::OUT_W-1:0]    val [jac_pkg::NUM_AXES];
  logic signed [jac_pkg::OUT_W-1:0]    trim_ext [jac_pkg::NUM_AXES];
  logic [jac_pkg::CALIB_W-1:0]         remain_q, remain_d;
  logic                                fin_q, fin_d;
  logic                                shut_q, shut_d;
  logic                                hold_q, hold_d;
  logic                                out_valid_q, out_valid_d;
  logic [jac_pkg::AXIS_W-1:0]          axis_q [jac_pkg::NUM_AXES];
  logic                                take;
  logic                                load_out;

  // While the new offsets are being written the stage takes nothing.
  assign in_ready_o = !fin_q && (!out_valid_q || out_ready_i);
  assign take       = in_valid_i && in_ready_o;
  assign step       = $signed({1'b0, trim_step_q});

  for (genvar a = 0; a < jac_pkg::NUM_AXES; a++) begin : g_axis
    jac_zdiv u_zdiv (
      .sum_i (sum_q[a]),
      .quo_o (zero_div[a])
    );

    if (a == jac_pkg::AX_THROTTLE) begin : g_abs
      assign meas[a] = $signed({{(jac_pkg::SUM_W-jac_pkg::AXIS_W){1'b0}}, scaled_i[a]});
    end else begin : g_ctr
      assign meas[a] = $signed({{(jac_pkg::SUM_W-jac_pkg::AXIS_W){1'b0}}, scaled_i[a]})
                       - jac_pkg::SUM_W'(jac_pkg::STICK_CENTER);
    end

    if (a == jac_pkg::AX_PITCH) begin : g_tp
      assign trim_ext[a] = jac_pkg::OUT_W'(pitch_trim_q);
    end else if (a == jac_pkg::AX_ROLL) begin : g_tr
      assign trim_ext[a] = jac_pkg::OUT_W'(roll_trim_q);
    end else begin : g_tn
      assign trim_ext[a] = '0;
    end

    assign val[a] = $signed({{(jac_pkg::OUT_W-jac_pkg::AXIS_W){1'b0}}, scaled_i[a]})
                    - jac_pkg::OUT_W'(zero_q[a]) + trim_ext[a];
  end

  always_comb begin
    pitch_trim_d = pitch_trim_q;
    roll_trim_d  = roll_trim_q;
    shut_d       = shut_q;
    hold_d       = hold_q;
    remain_d     = remain_q;
    fin_d        = 1'b0;
    load_out     = 1'b0;
    for (int a = 0; a < jac_pkg::NUM_AXES; a++) begin
      sum_d[a] = sum_q[a];
    end
    if (take) begin
      if (item_i.action) begin
        pitch_trim_d = '0;
        roll_trim_d  = '0;
        unique case (item_i.key)
          jac_pkg::KEY_UP: pitch_trim_d = step;
          jac_pkg::KEY_DN: pitch_trim_d = -step;
          jac_pkg::KEY_LT: roll_trim_d  = -step;
          jac_pkg::KEY_RT: roll_trim_d  = step;
          jac_pkg::KEY_LX: shut_d       = 1'b1;
          jac_pkg::KEY_RX: hold_d       = 1'b1;
          jac_pkg::KEY_RX_LONG: begin
            for (int a = 0; a < jac_pkg::NUM_AXES; a++) begin
              sum_d[a] = '0;
            end
            remain_d = jac_pkg::CALIB_W'(jac_pkg::CALIB_SAMPLES);
          end
          default: ;
        endcase
      end else if (remain_q != '0) begin
        for (int a = 0; a < jac_pkg::NUM_AXES; a++) begin
          sum_d[a] = sum_q[a] + meas[a];
        end
        remain_d = remain_q - jac_pkg::CALIB_W'(1);
        fin_d    = (remain_q == jac_pkg::CALIB_W'(1));
      end else begin
        load_out = 1'b1;
      end
    end
    out_valid_d = load_out || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_step_q  <= jac_pkg::TRIM_STEP_W'(jac_pkg::TRIM_STEP_RESET);
      pitch_trim_q <= '0;
      roll_trim_q  <= '0;
      remain_q     <= '0;
      fin_q        <= 1'b0;
      shut_q       <= 1'b0;
      hold_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int a = 0; a < jac_pkg::NUM_AXES; a++) begin
        sum_q[a]  <= '0;
        zero_q[a] <= '0;
      end
    end else begin
      if (cfg_wr_en_i) begin
        trim_step_q <= cfg_wr_data_i;
      end
      pitch_trim_q <= pitch_trim_d;
      roll_trim_q  <= roll_trim_d;
      remain_q     <= remain_d;
      fin_q        <= fin_d;
      shut_q       <= shut_d;
      hold_q       <= hold_d;
      out_valid_q  <= out_valid_d;
      for (int a = 0; a < jac_pkg::NUM_AXES; a++) begin
        sum_q[a] <= sum_d[a];
        if (fin_q) begin
          zero_q[a] <= zero_div[a];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      for (int a = 0; a < jac_pkg::NUM_AXES; a++) begin
        axis_q[a] <= jac_pkg::clamp_axis(val[a]);
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign axis_o        = axis_q;
  assign stop_req_o    = shut_q;
  assign hold_height_o = hold_q;

endmodule

// ===== design/joystick_axis_conditioner.sv =====
// Top level of the joystick axis conditioner: four scaling lanes feeding the merging stage.
//
//  Channel   Direction  Signals                          Contents
//  s_axis    in         tvalid tready tdata[55:0] tuser  raw axes and key code, tuser = action
//  m_axis    out        tvalid tready tdata[47:0]        conditioned axes and request flags
//  cfg       in         cfg_wr_en cfg_wr_data[6:0]       trim step
//
// One beat is taken per cycle unless the output stalls or a calibration bubble intervenes;
// a sample is caught by the lane multiply register, then the lane scale register, and then,
// unless it is a key action or calibration sample, the output register for its result.
// The cycle after the last calibration sample the merging stage writes the new offsets
// and takes nothing, so a bubble follows each calibration.
// Reset clears offsets, trims, sums, flags and the stage valids; the trim step returns to 10.
// A stalled output beat holds in its register while the stages behind it keep filling.
module joystick_axis_conditioner (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_wr_en_i,
  input  logic [jac_pkg::TRIM_STEP_W-1:0]   cfg_wr_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // raw_throttle, raw_yaw, raw_pitch, raw_roll, key_code, zero pad
  input  logic [jac_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // action
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // throttle, yaw, pitch, roll, stop_req, hold_height, zero pad
  output logic [jac_pkg::M_TDATA_W-1:0]     m_axis_tdata_o
);

  localparam int KEY_LSB = jac_pkg::NUM_AXES * jac_pkg::RAW_W;
  localparam int FLG_LSB = jac_pkg::NUM_AXES * jac_pkg::AXIS_W;

  logic                       v1_q, v1_d, v2_q, v2_d;
  jac_pkg::item_t             item1_q, item2_q, item_in;
  logic                       en1, s1_move, s2_move, merge_ready;
  logic [jac_pkg::AXIS_W-1:0] scaled [jac_pkg::NUM_AXES];
  logic [jac_pkg::AXIS_W-1:0] axis [jac_pkg::NUM_AXES];
  logic                       stop_req, hold_height;

  assign item_in.action = s_axis_tuser_i;
  assign item_in.key    = s_axis_tdata_i[KEY_LSB +: jac_pkg::KEY_W];

  assign s2_move         = v2_q && merge_ready;
  assign s1_move         = v1_q && (!v2_q || s2_move);
  assign s_axis_tready_o = !v1_q || s1_move;
  assign en1             = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    v1_d = en1 ? 1'b1 : (s1_move ? 1'b0 : v1_q);
    v2_d = s1_move ? 1'b1 : (s2_move ? 1'b0 : v2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      item1_q <= item_in;
    end
    if (s1_move) begin
      item2_q <= item1_q;
    end
  end

  for (genvar a = 0; a < jac_pkg::NUM_AXES; a++) begin : g_lane
    jac_lane u_lane (
      .clk_i    (clk_i),
      .en1_i    (en1),
      .en2_i    (s1_move),
      .raw_i    (s_axis_tdata_i[a*jac_pkg::RAW_W +: jac_pkg::RAW_W]),
      .scaled_o (scaled[a])
    );
  end

  jac_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (v2_q),
    .in_ready_o    (merge_ready),
    .item_i        (item2_q),
    .scaled_i      (scaled),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .axis_o        (axis),
    .stop_req_o    (stop_req),
    .hold_height_o (hold_height)
  );

  always_comb begin
    m_axis_tdata_o = '0;
    for (int a = 0; a < jac_pkg::NUM_AXES; a++) begin
      m_axis_tdata_o[a*jac_pkg::AXIS_W +: jac_pkg::AXIS_W] = axis[a];
    end
    m_axis_tdata_o[FLG_LSB]     = stop_req;
    m_axis_tdata_o[FLG_LSB + 1] = hold_height;
  end

endmodule
